### rtl/core/imuhd_pkg.sv
// Shared types and constants for the IMU sample correction and heading core.
// Depends on nothing; used by imu_sample_correct_heading_core.
package imuhd_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SUM,
    ST_MUL,
    ST_DIV,
    ST_PRE,
    ST_CORDIC,
    ST_POST,
    ST_FIN
  } state_e;

  // Register indexes
  localparam logic [2:0] REG_ACC_OFF_X = 3'd0;
  localparam logic [2:0] REG_ACC_OFF_Y = 3'd1;
  localparam logic [2:0] REG_ACC_OFF_Z = 3'd2;
  localparam logic [2:0] REG_GYR_OFF_X = 3'd3;
  localparam logic [2:0] REG_GYR_OFF_Y = 3'd4;
  localparam logic [2:0] REG_GYR_OFF_Z = 3'd5;
  localparam logic [2:0] REG_MAG_ADJ   = 3'd6;

  localparam int unsigned DIV_STEPS    = 21;
  localparam int unsigned CORDIC_ITERS = 20;
  localparam int unsigned ANG_FRAC     = 16;

  localparam logic signed [25:0] ANG_90  = 26'sd5898240;
  localparam logic signed [25:0] ANG_360 = 26'sd23592960;

  localparam logic signed [19:0] MAG_OUT_MAX = 20'sd524287;
  localparam logic signed [19:0] MAG_OUT_MIN = -20'sd524288;

  // CORDIC arctangent of 2^-i in units of 2^-16 degree
  function automatic logic [21:0] atan_lut(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/imu_sample_correct_heading_core.sv
// Top level of the IMU sample correction and heading core.
// Depends on imuhd_pkg (state type, register indexes, CORDIC angle table).
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i / in_ready_o, nine raw axes    | into core
//  out     | out_valid_o / out_ready_i, ten results    | out of core
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | APB slave
//
// Per item, after its accept: 3 mag scaling steps through the shared multiplier,
// one span sum, per mag axis one multiply and 21 restoring divide steps, one
// pre-rotation, 20 CORDIC iterations through one shift/add unit, one rounding
// and one output step. The next item is taken only after the output step.
// Reset presets the running min/max, the registers and the handshake state.
// A finished result sits in the output register; the next item is taken while
// it waits, and the sequencer holds in its last step only if that register is full.
module imu_sample_correct_heading_core #(
  parameter int SAMPLE_WIDTH      = 16,
  parameter int HEADING_FRAC_BITS = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] accel_raw_x_i,
  input  logic signed [15:0] accel_raw_y_i,
  input  logic signed [15:0] accel_raw_z_i,
  input  logic signed [15:0] gyro_raw_x_i,
  input  logic signed [15:0] gyro_raw_y_i,
  input  logic signed [15:0] gyro_raw_z_i,
  input  logic signed [15:0] mag_raw_x_i,
  input  logic signed [15:0] mag_raw_y_i,
  input  logic signed [15:0] mag_raw_z_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] accel_out_x_o,
  output logic signed [17:0] accel_out_y_o,
  output logic signed [17:0] accel_out_z_o,
  output logic signed [17:0] gyro_out_x_o,
  output logic signed [17:0] gyro_out_y_o,
  output logic signed [17:0] gyro_out_z_o,
  output logic signed [19:0] mag_out_x_o,
  output logic signed [19:0] mag_out_y_o,
  output logic signed [19:0] mag_out_z_o,
  output logic        [15:0] heading_angle_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [4:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam int SX_SH  = 16 - SAMPLE_WIDTH;
  localparam int HSHIFT = imuhd_pkg::ANG_FRAC - HEADING_FRAC_BITS;
  localparam logic [24:0] H_RND  = 25'(1) << (HSHIFT - 1);
  localparam logic [24:0] H_FULL = 25'(360) << HEADING_FRAC_BITS;

  // ---------------- configuration registers ----------------
  logic signed [16:0] off_q [6];
  logic        [23:0] mag_adj_q;
  logic        [2:0]  reg_idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) off_q[k] <= '0;
      mag_adj_q <= 24'h808080;
    end else if (wr_en) begin
      case (reg_idx)
        imuhd_pkg::REG_ACC_OFF_X: off_q[0] <= pwdata[16:0];
        imuhd_pkg::REG_ACC_OFF_Y: off_q[1] <= pwdata[16:0];
        imuhd_pkg::REG_ACC_OFF_Z: off_q[2] <= pwdata[16:0];
        imuhd_pkg::REG_GYR_OFF_X: off_q[3] <= pwdata[16:0];
        imuhd_pkg::REG_GYR_OFF_Y: off_q[4] <= pwdata[16:0];
        imuhd_pkg::REG_GYR_OFF_Z: off_q[5] <= pwdata[16:0];
        imuhd_pkg::REG_MAG_ADJ:   mag_adj_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      imuhd_pkg::REG_ACC_OFF_X: prdata = {15'd0, off_q[0]};
      imuhd_pkg::REG_ACC_OFF_Y: prdata = {15'd0, off_q[1]};
      imuhd_pkg::REG_ACC_OFF_Z: prdata = {15'd0, off_q[2]};
      imuhd_pkg::REG_GYR_OFF_X: prdata = {15'd0, off_q[3]};
      imuhd_pkg::REG_GYR_OFF_Y: prdata = {15'd0, off_q[4]};
      imuhd_pkg::REG_GYR_OFF_Z: prdata = {15'd0, off_q[5]};
      imuhd_pkg::REG_MAG_ADJ:   prdata = {8'd0, mag_adj_q};
      default:                  prdata = '0;
    endcase
  end

  // ---------------- input sign extension ----------------
  function automatic logic signed [15:0] sx_in(input logic signed [15:0] v);
    logic signed [15:0] t;
    t = v <<< SX_SH;
    return t >>> SX_SH;
  endfunction

  logic signed [15:0] raw_in [6];
  logic signed [17:0] ag_new [6];
  always_comb begin
    raw_in[0] = sx_in(accel_raw_x_i);
    raw_in[1] = sx_in(accel_raw_y_i);
    raw_in[2] = sx_in(accel_raw_z_i);
    raw_in[3] = sx_in(gyro_raw_x_i);
    raw_in[4] = sx_in(gyro_raw_y_i);
    raw_in[5] = sx_in(gyro_raw_z_i);
    for (int k = 0; k < 6; k++) begin
      ag_new[k] = 18'(raw_in[k]) - 18'(off_q[k]);
    end
    // accel x, gyro y and gyro z change sign
    ag_new[0] = -ag_new[0];
    ag_new[4] = -ag_new[4];
    ag_new[5] = -ag_new[5];
  end

  // ---------------- sequencer ----------------
  imuhd_pkg::state_e state_q, state_d;
  logic [1:0] ax_q;
  logic [4:0] cnt_q;
  logic       out_valid_q;
  logic       in_acc;
  logic       fin_go;

  assign in_ready_o  = (state_q == imuhd_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign fin_go      = (state_q == imuhd_pkg::ST_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= imuhd_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      imuhd_pkg::ST_IDLE:   if (in_valid_i) state_d = imuhd_pkg::ST_SCALE;
      imuhd_pkg::ST_SCALE:  if (ax_q == 2'd2) state_d = imuhd_pkg::ST_SUM;
      imuhd_pkg::ST_SUM:    state_d = imuhd_pkg::ST_MUL;
      imuhd_pkg::ST_MUL:    state_d = imuhd_pkg::ST_DIV;
      imuhd_pkg::ST_DIV: begin
        if (cnt_q == 5'(imuhd_pkg::DIV_STEPS - 1)) begin
          state_d = (ax_q == 2'd2) ? imuhd_pkg::ST_PRE : imuhd_pkg::ST_MUL;
        end
      end
      imuhd_pkg::ST_PRE:    state_d = imuhd_pkg::ST_CORDIC;
      imuhd_pkg::ST_CORDIC: begin
        if (cnt_q == 5'(imuhd_pkg::CORDIC_ITERS - 1)) state_d = imuhd_pkg::ST_POST;
      end
      imuhd_pkg::ST_POST:   state_d = imuhd_pkg::ST_FIN;
      imuhd_pkg::ST_FIN:    if (fin_go) state_d = imuhd_pkg::ST_IDLE;
      default:              state_d = imuhd_pkg::ST_IDLE;
    endcase
  end

  // ---------------- datapath storage ----------------
  logic signed [17:0] ag_q [6];
  logic signed [15:0] rmag_q [3];
  logic signed [17:0] s_q [3];
  logic signed [17:0] mx_q [3];
  logic signed [17:0] mn_q [3];
  logic        [19:0] sum_q;
  logic signed [21:0] cal_q [3];
  logic        [21:0] rem_q;
  logic        [20:0] quo_q;
  logic        [20:0] dvs_q;
  logic               neg_q;
  logic               zspan_q;
  logic signed [19:0] mo_q [3];
  logic signed [30:0] cx_q, cy_q;
  logic signed [25:0] cz_q;
  logic               hzero_q;
  logic        [15:0] head_q;

  // shared multiplier
  logic signed [20:0] mul_a, mul_b;
  logic signed [41:0] prod;
  logic        [7:0]  fac_byte;
  logic signed [17:0] s_new;

  // per-axis terms for the calibration multiply
  logic signed [19:0] ctr_e;
  logic        [18:0] ctr_m;
  logic        [18:0] span;
  logic        [42:0] dvd;

  always_comb begin
    case (ax_q)
      2'd0:    fac_byte = mag_adj_q[7:0];
      2'd1:    fac_byte = mag_adj_q[15:8];
      default: fac_byte = mag_adj_q[23:16];
    endcase
    ctr_e = 20'(s_q[ax_q]) * 20'sd2 - 20'(mx_q[ax_q]) - 20'(mn_q[ax_q]);
    ctr_m = ctr_e[19] ? 19'(-ctr_e) : ctr_e[18:0];
    span  = 19'(20'(mx_q[ax_q]) - 20'(mn_q[ax_q]));
    if (state_q == imuhd_pkg::ST_SCALE) begin
      mul_a = 21'(rmag_q[ax_q]);
      mul_b = $signed({12'd0, 9'(fac_byte) + 9'd128});
    end else begin
      mul_a = $signed({2'd0, ctr_m});
      mul_b = $signed({1'b0, sum_q});
    end
    prod  = mul_a * mul_b;
    s_new = 18'(prod >>> 7);
    dvd   = {prod[39:0], 3'b000} + 43'(span) * 43'd3;
  end

  // restoring divide step
  logic [21:0] rem_sh;
  logic [22:0] trial;
  logic        qbit;
  always_comb begin
    rem_sh = {rem_q[20:0], quo_q[20]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
    qbit   = !trial[22];
  end

  // saturation and CORDIC pre-rotation
  function automatic logic signed [19:0] sat20(input logic signed [22:0] v);
    if (v > 23'(imuhd_pkg::MAG_OUT_MAX)) return imuhd_pkg::MAG_OUT_MAX;
    if (v < 23'(imuhd_pkg::MAG_OUT_MIN)) return imuhd_pkg::MAG_OUT_MIN;
    return v[19:0];
  endfunction

  logic signed [19:0] sa, sb, sc;
  always_comb begin
    sa = sat20(23'(cal_q[1]));
    sb = sat20(-23'(cal_q[0]));
    sc = sat20(23'(cal_q[2]));
  end

  // CORDIC step
  logic signed [30:0] xs, ys;
  logic signed [25:0] ang;
  always_comb begin
    xs  = cx_q >>> cnt_q;
    ys  = cy_q >>> cnt_q;
    ang = $signed({4'd0, imuhd_pkg::atan_lut(cnt_q)});
  end

  // angle wrap and rounding
  logic signed [25:0] zw;
  logic        [24:0] hr;
  logic        [24:0] hf;
  always_comb begin
    zw = cz_q;
    if (zw < 0) zw = zw + imuhd_pkg::ANG_360;
    if (zw >= imuhd_pkg::ANG_360) zw = zw - imuhd_pkg::ANG_360;
    hr = (zw[24:0] + H_RND) >> HSHIFT;
    hf = (hr >= H_FULL) ? hr - H_FULL : hr;
  end

  // control counters and running extremes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        mx_q[k] <= -18'sd131072;
        mn_q[k] <= 18'sd131071;
      end
    end else begin
      if (fin_go) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        imuhd_pkg::ST_IDLE: begin
          ax_q  <= '0;
          cnt_q <= '0;
        end
        imuhd_pkg::ST_SCALE: begin
          if (s_new > mx_q[ax_q]) mx_q[ax_q] <= s_new;
          if (s_new < mn_q[ax_q]) mn_q[ax_q] <= s_new;
          ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
        end
        imuhd_pkg::ST_MUL: cnt_q <= '0;
        imuhd_pkg::ST_DIV: begin
          if (cnt_q == 5'(imuhd_pkg::DIV_STEPS - 1)) begin
            cnt_q <= '0;
            ax_q  <= ax_q + 2'd1;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        imuhd_pkg::ST_PRE:    cnt_q <= '0;
        imuhd_pkg::ST_CORDIC: cnt_q <= cnt_q + 5'd1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      imuhd_pkg::ST_IDLE: begin
        if (in_acc) begin
          for (int k = 0; k < 6; k++) ag_q[k] <= ag_new[k];
          rmag_q[0] <= sx_in(mag_raw_x_i);
          rmag_q[1] <= sx_in(mag_raw_y_i);
          rmag_q[2] <= sx_in(mag_raw_z_i);
        end
      end
      imuhd_pkg::ST_SCALE: s_q[ax_q] <= s_new;
      imuhd_pkg::ST_SUM: begin
        sum_q <= (20'(mx_q[0]) - 20'(mn_q[0])) + (20'(mx_q[1]) - 20'(mn_q[1]))
               + (20'(mx_q[2]) - 20'(mn_q[2]));
      end
      imuhd_pkg::ST_MUL: begin
        rem_q   <= dvd[42:21];
        quo_q   <= dvd[20:0];
        dvs_q   <= 21'(span) * 21'd6;
        neg_q   <= ctr_e[19];
        zspan_q <= (span == '0);
      end
      imuhd_pkg::ST_DIV: begin
        rem_q <= qbit ? trial[21:0] : rem_sh;
        quo_q <= {quo_q[19:0], qbit};
        if (cnt_q == 5'(imuhd_pkg::DIV_STEPS - 1)) begin
          if (zspan_q) cal_q[ax_q] <= '0;
          else if (neg_q) cal_q[ax_q] <= -$signed({1'b0, quo_q[19:0], qbit});
          else cal_q[ax_q] <= $signed({1'b0, quo_q[19:0], qbit});
        end
      end
      imuhd_pkg::ST_PRE: begin
        mo_q[0] <= sa;
        mo_q[1] <= sb;
        mo_q[2] <= sc;
        hzero_q <= (sa == '0) && (sb == '0);
        if (sb < 0) begin
          if (sa >= 0) begin
            cx_q <= 31'(sa) <<< 8;
            cy_q <= -(31'(sb) <<< 8);
            cz_q <= imuhd_pkg::ANG_90;
          end else begin
            cx_q <= -(31'(sa) <<< 8);
            cy_q <= 31'(sb) <<< 8;
            cz_q <= -imuhd_pkg::ANG_90;
          end
        end else begin
          cx_q <= 31'(sb) <<< 8;
          cy_q <= 31'(sa) <<< 8;
          cz_q <= '0;
        end
      end
      imuhd_pkg::ST_CORDIC: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + ang;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - ang;
        end
      end
      imuhd_pkg::ST_POST: head_q <= hzero_q ? 16'd0 : hf[15:0];
      imuhd_pkg::ST_FIN: begin
        if (fin_go) begin
          accel_out_x_o   <= ag_q[0];
          accel_out_y_o   <= ag_q[1];
          accel_out_z_o   <= ag_q[2];
          gyro_out_x_o    <= ag_q[3];
          gyro_out_y_o    <= ag_q[4];
          gyro_out_z_o    <= ag_q[5];
          mag_out_x_o     <= mo_q[0];
          mag_out_y_o     <= mo_q[1];
          mag_out_z_o     <= mo_q[2];
          heading_angle_o <= head_q;
        end
      end
      default: ;
    endcase
  end

endmodule

### tb/sv/tb.sv
// Self-checking testbench for imu_sample_correct_heading_core.
// Depends on imuhd_pkg and the core RTL; predicts each result with its own
// model of offset removal, mag hard/soft-iron calibration and CORDIC heading.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 250;

  typedef struct {
    logic signed [15:0] acc[3];
    logic signed [15:0] gyr[3];
    logic signed [15:0] mag[3];
  } sample_t;

  typedef struct {
    logic [17:0] acc[3];
    logic [17:0] gyr[3];
    logic [19:0] mag[3];
    logic [15:0] hdg;
  } corrected_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [17:0] accel_out_x_o, accel_out_y_o, accel_out_z_o;
  logic signed [17:0] gyro_out_x_o, gyro_out_y_o, gyro_out_z_o;
  logic signed [19:0] mag_out_x_o, mag_out_y_o, mag_out_z_o;
  logic [15:0] heading_angle_o;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  sample_t cur_sample;
  sample_t pending_samples[$];
  corrected_t expected_results[$];

  // predictor copy of registers and calibration state
  longint acc_bias[3];
  longint gyr_bias[3];
  logic [23:0] mag_gain_bytes;
  longint mag_hi[3];
  longint mag_lo[3];

  int unsigned n_errors;
  int unsigned idle_cycles;
  bit in_taken;
  bit out_taken;
  bit no_idle;
  int unsigned send_gap;
  int unsigned recv_gap;

  imu_sample_correct_heading_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .accel_raw_x_i  (cur_sample.acc[0]),
    .accel_raw_y_i  (cur_sample.acc[1]),
    .accel_raw_z_i  (cur_sample.acc[2]),
    .gyro_raw_x_i   (cur_sample.gyr[0]),
    .gyro_raw_y_i   (cur_sample.gyr[1]),
    .gyro_raw_z_i   (cur_sample.gyr[2]),
    .mag_raw_x_i    (cur_sample.mag[0]),
    .mag_raw_y_i    (cur_sample.mag[1]),
    .mag_raw_z_i    (cur_sample.mag[2]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accel_out_x_o  (accel_out_x_o),
    .accel_out_y_o  (accel_out_y_o),
    .accel_out_z_o  (accel_out_z_o),
    .gyro_out_x_o   (gyro_out_x_o),
    .gyro_out_y_o   (gyro_out_y_o),
    .gyro_out_z_o   (gyro_out_z_o),
    .mag_out_x_o    (mag_out_x_o),
    .mag_out_y_o    (mag_out_y_o),
    .mag_out_z_o    (mag_out_z_o),
    .heading_angle_o(heading_angle_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sext17(logic [31:0] v);
    return longint'($signed(v[16:0]));
  endfunction

  // soft-iron scaled, hard-iron centered axis in 1/8 count, ties away from zero
  function automatic longint calib_axis(longint s, longint hi, longint lo, longint span_sum);
    longint span, num, den, q;
    bit neg;
    span = hi - lo;
    if (span <= 0) return 0;
    num = (2 * s - hi - lo) * span_sum * 4;
    den = 3 * span;
    neg = num < 0;
    if (neg) num = -num;
    q = (2 * num + den) / (2 * den);
    return neg ? -q : q;
  endfunction

  function automatic longint sat_mag(longint v);
    if (v > longint'(imuhd_pkg::MAG_OUT_MAX)) return longint'(imuhd_pkg::MAG_OUT_MAX);
    if (v < longint'(imuhd_pkg::MAG_OUT_MIN)) return longint'(imuhd_pkg::MAG_OUT_MIN);
    return v;
  endfunction

  // CORDIC vectoring atan2, angle kept in 2^-16 degree
  function automatic logic [15:0] heading_deg(longint a, longint b);
    longint x, y, z, nx, ny, h, full;
    full = longint'(360) <<< imuhd_pkg::ANG_FRAC;
    z = 0;
    if (a == 0 && b == 0) return 16'd0;
    if (b < 0) begin
      if (a >= 0) begin
        x = a; y = -b; z = longint'(90) <<< imuhd_pkg::ANG_FRAC;
      end else begin
        x = -a; y = b; z = -(longint'(90) <<< imuhd_pkg::ANG_FRAC);
      end
    end else begin
      x = b; y = a;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < imuhd_pkg::CORDIC_ITERS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + longint'(imuhd_pkg::atan_lut(i[4:0]));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - longint'(imuhd_pkg::atan_lut(i[4:0]));
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = z + full;
    if (z >= full) z = z - full;
    h = (z + (longint'(1) <<< (imuhd_pkg::ANG_FRAC - 7 - 1))) >>> (imuhd_pkg::ANG_FRAC - 7);
    if (h >= (longint'(360) <<< 7)) h = h - (longint'(360) <<< 7);
    return h[15:0];
  endfunction

  // advances the min/max state and returns the corrected item
  function automatic corrected_t correct_sample(sample_t smp);
    corrected_t res;
    longint scaled[3];
    longint cal[3];
    longint span_sum, mx, my, mz, t;
    for (int i = 0; i < 3; i++) begin
      t = longint'(smp.acc[i]) - acc_bias[i];
      if (i == 0) t = -t;
      res.acc[i] = t[17:0];
      t = longint'(smp.gyr[i]) - gyr_bias[i];
      if (i != 0) t = -t;
      res.gyr[i] = t[17:0];
      scaled[i] = (longint'(smp.mag[i]) * (longint'(mag_gain_bytes[8*i +: 8]) + 128)) >>> 7;
      if (scaled[i] > mag_hi[i]) mag_hi[i] = scaled[i];
      if (scaled[i] < mag_lo[i]) mag_lo[i] = scaled[i];
    end
    span_sum = 0;
    for (int i = 0; i < 3; i++) span_sum = span_sum + mag_hi[i] - mag_lo[i];
    for (int i = 0; i < 3; i++) cal[i] = calib_axis(scaled[i], mag_hi[i], mag_lo[i], span_sum);
    mx = sat_mag(cal[1]);
    my = sat_mag(-cal[0]);
    mz = sat_mag(cal[2]);
    res.mag[0] = mx[19:0];
    res.mag[1] = my[19:0];
    res.mag[2] = mz[19:0];
    res.hdg = heading_deg(mx, my);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    n_errors++;
  endtask

  function automatic sample_t make_sample(int a, int g, int mx, int my, int mz);
    sample_t smp;
    for (int i = 0; i < 3; i++) begin
      smp.acc[i] = 16'(a);
      smp.gyr[i] = 16'(g);
    end
    smp.mag[0] = 16'(mx); smp.mag[1] = 16'(my); smp.mag[2] = 16'(mz);
    return smp;
  endfunction

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cur_sample <= make_sample(0, 0, 0, 0, 0);
    end else begin
      if (in_valid_i && !in_taken) begin
        // hold item until accepted
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        cur_sample <= pending_samples[0];
        in_valid_i <= 1'b1;
        send_gap <= no_idle ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_taken <= 1'b0;
    if (in_valid_i && in_ready_o) begin
      in_taken <= 1'b1;
      expected_results.push_back(correct_sample(pending_samples.pop_front()));
    end
  end

  // result receiver with random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_ready_i && !out_taken) begin
        // keep ready until a result is taken
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_gap <= no_idle ? 0 : $urandom_range(0, 13);
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    corrected_t want;
    out_taken <= 1'b0;
    if (out_valid_o && out_ready_i) begin
      out_taken <= 1'b1;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = expected_results.pop_front();
        if (accel_out_x_o !== want.acc[0]) report_mismatch("accel_x", accel_out_x_o, want.acc[0]);
        if (accel_out_y_o !== want.acc[1]) report_mismatch("accel_y", accel_out_y_o, want.acc[1]);
        if (accel_out_z_o !== want.acc[2]) report_mismatch("accel_z", accel_out_z_o, want.acc[2]);
        if (gyro_out_x_o !== want.gyr[0]) report_mismatch("gyro_x", gyro_out_x_o, want.gyr[0]);
        if (gyro_out_y_o !== want.gyr[1]) report_mismatch("gyro_y", gyro_out_y_o, want.gyr[1]);
        if (gyro_out_z_o !== want.gyr[2]) report_mismatch("gyro_z", gyro_out_z_o, want.gyr[2]);
        if (mag_out_x_o !== want.mag[0]) report_mismatch("mag_x", mag_out_x_o, want.mag[0]);
        if (mag_out_y_o !== want.mag[1]) report_mismatch("mag_y", mag_out_y_o, want.mag[1]);
        if (mag_out_z_o !== want.mag[2]) report_mismatch("mag_z", mag_out_z_o, want.mag[2]);
        if (heading_angle_o !== want.hdg) report_mismatch("heading", heading_angle_o, want.hdg);
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // register write through the config port, mirrored into the predictor
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      imuhd_pkg::REG_ACC_OFF_X: acc_bias[0] = sext17(val);
      imuhd_pkg::REG_ACC_OFF_Y: acc_bias[1] = sext17(val);
      imuhd_pkg::REG_ACC_OFF_Z: acc_bias[2] = sext17(val);
      imuhd_pkg::REG_GYR_OFF_X: gyr_bias[0] = sext17(val);
      imuhd_pkg::REG_GYR_OFF_Y: gyr_bias[1] = sext17(val);
      imuhd_pkg::REG_GYR_OFF_Z: gyr_bias[2] = sext17(val);
      imuhd_pkg::REG_MAG_ADJ:   mag_gain_bytes = val[23:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    wait (pending_samples.size() == 0 && expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_offsets(logic [31:0] v_acc, logic [31:0] v_gyr, logic [31:0] v_mag);
    write_reg(imuhd_pkg::REG_ACC_OFF_X, v_acc);
    write_reg(imuhd_pkg::REG_ACC_OFF_Y, v_gyr);
    write_reg(imuhd_pkg::REG_ACC_OFF_Z, v_acc ^ 32'h1_5555);
    write_reg(imuhd_pkg::REG_GYR_OFF_X, v_gyr);
    write_reg(imuhd_pkg::REG_GYR_OFF_Y, v_acc);
    write_reg(imuhd_pkg::REG_GYR_OFF_Z, v_gyr ^ 32'h0_aaaa);
    write_reg(imuhd_pkg::REG_MAG_ADJ, v_mag);
  endtask

  // random item; mag mostly within +/-1000, sometimes full range
  function automatic sample_t rand_sample();
    sample_t smp;
    for (int i = 0; i < 3; i++) begin
      smp.acc[i] = 16'($urandom);
      smp.gyr[i] = 16'($urandom);
      if ($urandom_range(0, 7) == 0) smp.mag[i] = 16'($urandom);
      else smp.mag[i] = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
    end
    return smp;
  endfunction

  task automatic run_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pending_samples.push_back(rand_sample());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    for (int i = 0; i < 3; i++) begin
      acc_bias[i] = 0; gyr_bias[i] = 0;
      mag_hi[i] = -131072; mag_lo[i] = 131071;
    end
    mag_gain_bytes = 24'h808080;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero span and both-zero heading first, then quadrants and extremes
    pending_samples.push_back(make_sample(0, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(1, -1, 0, 0, 0));
    pending_samples.push_back(make_sample(100, 200, 100, 0, 50));
    pending_samples.push_back(make_sample(-100, 5, 0, 100, -50));
    pending_samples.push_back(make_sample(7, 9, -100, 0, 0));
    pending_samples.push_back(make_sample(3, 4, 0, -100, 20));
    pending_samples.push_back(make_sample(3, 4, 60, 60, 0));
    pending_samples.push_back(make_sample(3, 4, -60, 60, 0));
    pending_samples.push_back(make_sample(3, 4, -60, -60, 0));
    pending_samples.push_back(make_sample(3, 4, 60, -60, 0));
    pending_samples.push_back(make_sample(32767, 32767, 32767, 32767, 32767));
    pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, -32768));
    pending_samples.push_back(make_sample(32767, -32768, 0, 0, 0));
    pending_samples.push_back(make_sample(-32768, 32767, 32767, -32768, 0));
    pending_samples.push_back(make_sample(0, 0, 16000, -16000, 12));
    wait_drained();

    // extreme settings: most negative offsets on four axes, largest gains
    set_offsets(32'hffff_0000, 32'h0001_0000, 32'h00ff_ffff);
    pending_samples.push_back(make_sample(32767, -32768, 32767, -32768, 32767));
    pending_samples.push_back(make_sample(-32768, 32767, -32768, 32767, -32768));
    pending_samples.push_back(make_sample(0, 0, 1, -1, 0));
    run_random(200);
    wait_drained();

    // other extreme: most positive offsets on two axes, smallest gains
    set_offsets(32'h0000_ffff, 32'h0001_ffff, 32'h0000_0000);
    pending_samples.push_back(make_sample(-32768, 32767, 32767, 32767, -32768));
    run_random(200);
    wait_drained();

    set_offsets($urandom, $urandom, $urandom);
    run_random(200);
    wait_drained();

    set_offsets($urandom, $urandom, 32'h0080_8080);
    run_random(200);
    wait_drained();

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
